[rtl/utf8_replace_invalid_stream_unit_defines.svh]
// Assertion macros shared by the UTF-8 sanitizer RTL.
`ifndef UTF8_REPLACE_INVALID_STREAM_UNIT_DEFINES_SVH
`define UTF8_REPLACE_INVALID_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define UTF8RI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8ri: same-cycle check failed");

// Next-cycle implication, off during reset.
`define UTF8RI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8ri: next-cycle check failed");

`endif

[rtl/utf8ri_pkg.sv]
// Package: types and constants of the UTF-8 sanitizer.
`default_nettype none
package utf8ri_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;

   // Replacement character U+FFFD in UTF-8
   localparam logic [7:0] REP_BYTE0 = 8'hEF;
   localparam logic [7:0] REP_BYTE1 = 8'hBF;
   localparam logic [7:0] REP_BYTE2 = 8'hBD;

   // Position inside an EF BF BD triple
   localparam logic [1:0] TRI_FIRST  = 2'd0;
   localparam logic [1:0] TRI_SECOND = 2'd1;
   localparam logic [1:0] TRI_THIRD  = 2'd2;

   // Work for the back end: reps replacements, then pass_cnt raw bytes.
   typedef struct packed {
      logic [2:0]      reps;
      logic [2:0]      pass_cnt;
      logic [3:0][7:0] bytes;
      logic            last;
   } cmd_type;

endpackage
`default_nettype wire

[rtl/utf8ri_front.sv]
// Front end: holds pending sequence bytes and turns input words into commands.
`default_nettype none
`include "utf8_replace_invalid_stream_unit_defines.svh"
module utf8ri_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire logic [7:0]         req_byte,
   input  wire logic               req_last,
   input  wire logic               q_full,
   output logic                    q_wr,
   output utf8ri_pkg::cmd_type     q_cmd
);

   logic [1:0] pend_cnt_ff, pend_cnt_in;
   logic [2:0] exp_len_ff, exp_len_in;
   logic [7:0] pend_ff [3];

   logic       accept;
   logic       active;
   logic       cont_ok;
   logic       complete;
   logic       lead_ascii;
   logic [2:0] lead_len;
   logic       go_lead;
   logic       lead_rep;
   logic [2:0] rej_reps;
   logic [2:0] reps;
   logic [2:0] pass_cnt;
   logic [1:0] src_n;
   logic       pend_wr;
   logic [1:0] pend_wr_idx;
   logic [1:0] cnt_mid;

   assign accept = req_push && !q_full;
   assign active = (pend_cnt_ff != 2'd0);

   // Lead byte class
   always_comb begin
      lead_ascii = !req_byte[7];
      if (req_byte >= 8'hC2 && req_byte <= 8'hDF) begin
         lead_len = 3'd2;
      end else if (req_byte >= 8'hE0 && req_byte <= 8'hEF) begin
         lead_len = 3'd3;
      end else if (req_byte >= 8'hF0 && req_byte <= 8'hF4) begin
         lead_len = 3'd4;
      end else begin
         lead_len = 3'd0;
      end
   end

   // Continuation check, with the second-byte range limits after E0, ED, F0, F4
   always_comb begin
      cont_ok = (req_byte[7:6] == 2'b10);
      if (pend_cnt_ff == 2'd1) begin
         if (pend_ff[0] == 8'hE0 && req_byte < 8'hA0) cont_ok = 1'b0;
         if (pend_ff[0] == 8'hED && req_byte >= 8'hA0) cont_ok = 1'b0;
         if (pend_ff[0] == 8'hF0 && req_byte < 8'h90) cont_ok = 1'b0;
         if (pend_ff[0] == 8'hF4 && req_byte >= 8'h90) cont_ok = 1'b0;
      end
   end

   assign complete = (({1'b0, pend_cnt_ff} + 3'd1) == exp_len_ff);

   always_comb begin
      go_lead     = 1'b0;
      lead_rep    = 1'b0;
      rej_reps    = 3'd0;
      pass_cnt    = 3'd0;
      src_n       = 2'd0;
      pend_wr     = 1'b0;
      pend_wr_idx = 2'd0;
      cnt_mid     = pend_cnt_ff;
      exp_len_in  = exp_len_ff;

      priority if (!active) begin
         go_lead = 1'b1;
      end else if (!cont_ok) begin
         // lead and held continuations each become a replacement
         go_lead  = 1'b1;
         rej_reps = {1'b0, pend_cnt_ff};
      end else if (complete) begin
         src_n      = pend_cnt_ff;
         pass_cnt   = {1'b0, pend_cnt_ff} + 3'd1;
         cnt_mid    = 2'd0;
         exp_len_in = 3'd0;
      end else begin
         pend_wr     = 1'b1;
         pend_wr_idx = pend_cnt_ff;
         cnt_mid     = pend_cnt_ff + 2'd1;
      end

      if (go_lead) begin
         cnt_mid    = 2'd0;
         exp_len_in = 3'd0;
         priority if (lead_ascii) begin
            pass_cnt = 3'd1;
         end else if (lead_len != 3'd0) begin
            pend_wr     = 1'b1;
            pend_wr_idx = 2'd0;
            cnt_mid     = 2'd1;
            exp_len_in  = lead_len;
         end else begin
            lead_rep = 1'b1;
         end
      end

      reps        = rej_reps + {2'b00, lead_rep};
      pend_cnt_in = cnt_mid;
      if (req_last) begin
         // end of text: every held byte becomes a replacement
         reps        = reps + {1'b0, cnt_mid};
         pend_cnt_in = 2'd0;
         exp_len_in  = 3'd0;
      end
   end

   always_comb begin
      q_cmd.reps     = reps;
      q_cmd.pass_cnt = pass_cnt;
      q_cmd.last     = req_last;
      for (int i = 0; i < 3; i++) begin
         q_cmd.bytes[i] = (2'(i) < src_n) ? pend_ff[i] : req_byte;
      end
      q_cmd.bytes[3] = req_byte;
   end

   assign q_wr = accept && ((reps != 3'd0) || (pass_cnt != 3'd0));

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff <= 2'd0;
         exp_len_ff  <= 3'd0;
      end else if (accept) begin
         pend_cnt_ff <= pend_cnt_in;
         exp_len_ff  <= exp_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pend_wr) begin
         pend_ff[pend_wr_idx] <= req_byte;
      end
   end

   `UTF8RI_ASSERT_IMPL(a_len_above_cnt, clock, reset, pend_cnt_ff != 2'd0, exp_len_ff > 3'(pend_cnt_ff))
   `UTF8RI_ASSERT_NEXT(a_last_flushes, clock, reset, accept && req_last, pend_cnt_ff == 2'd0 && exp_len_ff == 3'd0)

endmodule
`default_nettype wire

[rtl/utf8ri_queue.sv]
// Command queue between front end and back end.
`default_nettype none
`include "utf8_replace_invalid_stream_unit_defines.svh"
module utf8ri_queue #(
   parameter int DEPTH = utf8ri_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr,
   input  wire utf8ri_pkg::cmd_type  wr_data,
   output logic                      full,
   input  wire logic                 rd,
   output utf8ri_pkg::cmd_type       rd_data,
   output logic                      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   utf8ri_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr;
   logic             do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr && !full;
   assign do_rd   = rd && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `UTF8RI_ASSERT_IMPL(a_no_write_when_full, clock, reset, full, !wr)

endmodule
`default_nettype wire

[rtl/utf8ri_back.sv]
// Back end: expands each command into output words, one per cycle while rsp_pop is held.
`default_nettype none
`include "utf8_replace_invalid_stream_unit_defines.svh"
module utf8ri_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire utf8ri_pkg::cmd_type  q_cmd,
   input  wire logic                 q_empty,
   output logic                      q_rd,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [7:0]                rsp_byte,
   output logic                      rsp_is_replacement,
   output logic                      rsp_run_last,
   output logic                      rsp_text_end
);

   utf8ri_pkg::cmd_type cur_ff;
   logic       busy_ff, busy_in;
   logic [2:0] rep_left_ff, rep_left_in;
   logic [1:0] tri_ff, tri_in;
   logic [1:0] pass_idx_ff, pass_idx_in;

   logic       in_rep;
   logic       fire;
   logic       final_word;
   logic       take;

   assign in_rep = (rep_left_ff != 3'd0);
   assign fire   = busy_ff && rsp_pop;

   always_comb begin
      if (in_rep) begin
         unique case (tri_ff)
            utf8ri_pkg::TRI_FIRST:  rsp_byte = utf8ri_pkg::REP_BYTE0;
            utf8ri_pkg::TRI_SECOND: rsp_byte = utf8ri_pkg::REP_BYTE1;
            default:                rsp_byte = utf8ri_pkg::REP_BYTE2;
         endcase
         final_word = (tri_ff == utf8ri_pkg::TRI_THIRD) && (rep_left_ff == 3'd1) &&
                      (cur_ff.pass_cnt == 3'd0);
      end else begin
         rsp_byte   = cur_ff.bytes[pass_idx_ff];
         final_word = ({1'b0, pass_idx_ff} == (cur_ff.pass_cnt - 3'd1));
      end
   end

   assign rsp_empty          = !busy_ff;
   assign rsp_is_replacement = in_rep;
   assign rsp_run_last       = final_word;
   assign rsp_text_end       = final_word && cur_ff.last;

   // next command is pulled as the current one delivers its final word, or at once when idle
   assign take = !busy_ff || (fire && final_word);
   assign q_rd = take && !q_empty;

   always_comb begin
      busy_in     = busy_ff;
      rep_left_in = rep_left_ff;
      tri_in      = tri_ff;
      pass_idx_in = pass_idx_ff;
      if (take) begin
         busy_in     = !q_empty;
         rep_left_in = q_cmd.reps;
         tri_in      = utf8ri_pkg::TRI_FIRST;
         pass_idx_in = 2'd0;
      end else if (fire) begin
         if (in_rep) begin
            if (tri_ff == utf8ri_pkg::TRI_THIRD) begin
               tri_in      = utf8ri_pkg::TRI_FIRST;
               rep_left_in = rep_left_ff - 3'd1;
            end else begin
               tri_in = tri_ff + 2'd1;
            end
         end else begin
            pass_idx_in = pass_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         rep_left_ff <= 3'd0;
         tri_ff      <= utf8ri_pkg::TRI_FIRST;
         pass_idx_ff <= 2'd0;
      end else begin
         busy_ff     <= busy_in;
         rep_left_ff <= rep_left_in;
         tri_ff      <= tri_in;
         pass_idx_ff <= pass_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_rd) begin
         cur_ff <= q_cmd;
      end
   end

   `UTF8RI_ASSERT_IMPL(a_pass_has_bytes, clock, reset, busy_ff && !in_rep, cur_ff.pass_cnt != 3'd0)
   `UTF8RI_ASSERT_IMPL(a_rep_bound, clock, reset, busy_ff, rep_left_ff <= 3'd4 && tri_ff != 2'd3)

endmodule
`default_nettype wire

[rtl/utf8_replace_invalid_stream_unit.sv]
// UTF-8 sanitizer: passes well-formed UTF-8, replaces bad bytes with EF BF BD.
// Input words enter at up to one per cycle while the command queue has room; each
// input word yields 0 to 12 output words, and the back end delivers one output word
// per cycle while rsp_pop is held, so a byte that is replaced costs three output words.
// The first output word of an input is written into the command queue at the edge that
// accepts it, then loaded into the back-end register, and only then is on the result
// ports, where it can be popped. Up to QUEUE_DEPTH decoded commands wait between the
// front end and the back end, so input keeps flowing while the output side stalls,
// until the queue fills. An input that only extends a pending sequence gives no output.
`default_nettype none
module utf8_replace_invalid_stream_unit #(
   parameter int QUEUE_DEPTH = utf8ri_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_byte,
   input  wire logic       req_last,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_byte,
   output logic            rsp_is_replacement,
   output logic            rsp_run_last,
   output logic            rsp_text_end
);

   utf8ri_pkg::cmd_type wr_cmd;
   utf8ri_pkg::cmd_type rd_cmd;
   logic q_wr;
   logic q_full;
   logic q_rd;
   logic q_empty;

   assign req_full = q_full;

   utf8ri_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_byte (req_byte),
      .req_last (req_last),
      .q_full   (q_full),
      .q_wr     (q_wr),
      .q_cmd    (wr_cmd)
   );

   utf8ri_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (q_wr),
      .wr_data (wr_cmd),
      .full    (q_full),
      .rd      (q_rd),
      .rd_data (rd_cmd),
      .empty   (q_empty)
   );

   utf8ri_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_cmd              (rd_cmd),
      .q_empty            (q_empty),
      .q_rd               (q_rd),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_byte           (rsp_byte),
      .rsp_is_replacement (rsp_is_replacement),
      .rsp_run_last       (rsp_run_last),
      .rsp_text_end       (rsp_text_end)
   );

endmodule
`default_nettype wire
